/* design/cpu8080_alu_with_flags_defines.svh */
// Assertion macros shared by the ALU checker.
`ifndef CPU8080_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU8080_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ALU80_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alu80 check failed");

// Next-cycle implication, disabled while reset is high.
`define ALU80_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alu80 check failed");

`endif

/* design/alu80_pkg.sv */
// Types and operation codes for the 8080 ALU.
package alu80_pkg;

   localparam logic [3:0] FUNC_ADD = 4'd0;
   localparam logic [3:0] FUNC_ADC = 4'd1;
   localparam logic [3:0] FUNC_SUB = 4'd2;
   localparam logic [3:0] FUNC_SBB = 4'd3;
   localparam logic [3:0] FUNC_ANA = 4'd4;
   localparam logic [3:0] FUNC_XRA = 4'd5;
   localparam logic [3:0] FUNC_ORA = 4'd6;
   localparam logic [3:0] FUNC_CMP = 4'd7;
   localparam logic [3:0] FUNC_INR = 4'd8;
   localparam logic [3:0] FUNC_DCR = 4'd9;
   localparam logic [3:0] FUNC_RLC = 4'd10;
   localparam logic [3:0] FUNC_RRC = 4'd11;
   localparam logic [3:0] FUNC_RAL = 4'd12;
   localparam logic [3:0] FUNC_RAR = 4'd13;
   localparam logic [3:0] FUNC_STC = 4'd14;

   // flag update masks: sign, zero, aux, parity, carry from bit 4 down
   localparam logic [4:0] CHG_ALL      = 5'b11111;
   localparam logic [4:0] CHG_NO_CARRY = 5'b11110;
   localparam logic [4:0] CHG_CARRY    = 5'b00001;
   localparam logic [4:0] CHG_NONE     = 5'b00000;

   typedef struct packed {
      logic [3:0] func;
      logic [7:0] acc_in;
      logic [7:0] operand;
      logic       carry_in;
   } alu80_req_type;

   typedef struct packed {
      logic [7:0] value_out;
      logic       value_written;
      logic       sign_flag;
      logic       zero_flag;
      logic       aux_flag;
      logic       parity_flag;
      logic       carry_flag;
      logic [4:0] flags_changed;
   } alu80_rsp_type;

endpackage

/* design/alu80_core.sv */
// Combinational 8080 ALU datapath and flag logic.
module alu80_core (
   input  alu80_pkg::alu80_req_type req,
   output alu80_pkg::alu80_rsp_type rsp
);
   import alu80_pkg::*;

   logic       sub_op;
   logic       add_cin;
   logic [7:0] add_b;
   logic [8:0] add_sum;
   logic [4:0] nib_sum;
   logic [7:0] res;
   logic       wr;
   logic       aux;
   logic       cy;
   logic [4:0] chg;

   // shared adder: subtraction is a + ~b + !borrow
   always_comb begin
      sub_op  = (req.func == FUNC_SUB) || (req.func == FUNC_SBB) || (req.func == FUNC_CMP);
      add_b   = sub_op ? ~req.operand : req.operand;
      unique case (req.func)
         FUNC_ADC: add_cin = req.carry_in;
         FUNC_SUB, FUNC_CMP: add_cin = 1'b1;
         FUNC_SBB: add_cin = ~req.carry_in;
         default:  add_cin = 1'b0;
      endcase
      add_sum = {1'b0, req.acc_in} + {1'b0, add_b} + {8'd0, add_cin};
      nib_sum = {1'b0, req.acc_in[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
   end

   always_comb begin
      res = req.acc_in;
      wr  = 1'b1;
      aux = 1'b0;
      cy  = req.carry_in;
      chg = CHG_ALL;
      unique case (req.func)
         FUNC_ADD, FUNC_ADC: begin
            res = add_sum[7:0];
            cy  = add_sum[8];
            aux = nib_sum[4];
         end
         FUNC_SUB, FUNC_SBB, FUNC_CMP: begin
            res = add_sum[7:0];
            cy  = ~add_sum[8];
            aux = nib_sum[4];
            wr  = (req.func != FUNC_CMP);
         end
         FUNC_ANA: begin
            res = req.acc_in & req.operand;
            aux = req.acc_in[3] | req.operand[3];
            cy  = 1'b0;
         end
         FUNC_XRA: begin
            res = req.acc_in ^ req.operand;
            cy  = 1'b0;
         end
         FUNC_ORA: begin
            res = req.acc_in | req.operand;
            cy  = 1'b0;
         end
         FUNC_INR: begin
            res = req.operand + 8'd1;
            aux = (req.operand[3:0] == 4'hf);
            chg = CHG_NO_CARRY;
         end
         FUNC_DCR: begin
            res = req.operand - 8'd1;
            aux = (req.operand[3:0] != 4'h0);
            chg = CHG_NO_CARRY;
         end
         FUNC_RLC: begin
            res = {req.acc_in[6:0], req.acc_in[7]};
            cy  = req.acc_in[7];
            chg = CHG_CARRY;
         end
         FUNC_RRC: begin
            res = {req.acc_in[0], req.acc_in[7:1]};
            cy  = req.acc_in[0];
            chg = CHG_CARRY;
         end
         FUNC_RAL: begin
            res = {req.acc_in[6:0], req.carry_in};
            cy  = req.acc_in[7];
            chg = CHG_CARRY;
         end
         FUNC_RAR: begin
            res = {req.carry_in, req.acc_in[7:1]};
            cy  = req.acc_in[0];
            chg = CHG_CARRY;
         end
         FUNC_STC: begin
            cy  = 1'b1;
            wr  = 1'b0;
            chg = CHG_CARRY;
         end
         default: begin
            wr  = 1'b0;
            chg = CHG_NONE;
         end
      endcase
   end

   always_comb begin
      rsp.value_out     = wr ? res : req.acc_in;
      rsp.value_written = wr;
      rsp.sign_flag     = chg[4] & res[7];
      rsp.zero_flag     = chg[3] & (res == 8'd0);
      rsp.aux_flag      = chg[2] & aux;
      rsp.parity_flag   = chg[1] & ~(^res);
      rsp.carry_flag    = cy;
      rsp.flags_changed = chg;
   end

endmodule

/* design/cpu8080_alu_with_flags.sv */
// 8080 ALU: an accepted word is held in the input register and its result in the result register,
// which drives the outputs. Throughput one word per cycle: input register, one pass of ALU logic, result register.
// busy is always low; the receiver cannot stall and needs no holding.
// Synchronous active-high reset clears the valid bits; payload registers are not reset.
// The result shows on rsp_data for one cycle with rsp_strobe high.
module cpu8080_alu_with_flags (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  alu80_pkg::alu80_req_type req_data,
   output logic                     rsp_strobe,
   output alu80_pkg::alu80_rsp_type rsp_data
);
   import alu80_pkg::*;

   logic          req_valid_ff;
   logic          req_valid_in;
   alu80_req_type req_ff;
   alu80_req_type req_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   alu80_rsp_type rsp_ff;
   alu80_rsp_type rsp_in;
   alu80_rsp_type alu_rsp;

   assign busy = 1'b0;

   assign req_valid_in = start & ~busy;
   assign req_in       = req_data;
   assign rsp_valid_in = req_valid_ff;
   assign rsp_in       = alu_rsp;

   alu80_core u_core (
      .req (req_ff),
      .rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* design/alu80_checker.sv */
// Port-level checks for the 8080 ALU and the bind that attaches them.
`include "cpu8080_alu_with_flags_defines.svh"

module alu80_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input alu80_pkg::alu80_req_type req_data,
   input logic                     rsp_strobe,
   input alu80_pkg::alu80_rsp_type rsp_data
);
   import alu80_pkg::*;

   // every accepted word comes out on rsp_strobe after the input and result registers
   `ALU80_ASSERT_NEXT(a_word_out, clock, reset, start && !busy, ##1 rsp_strobe)

   // no result without an accepted word behind it
   `ALU80_ASSERT_IMPLY(a_no_extra, clock, reset, rsp_strobe, $past(start && !busy, 2))

   // an unwritten destination passes the accumulator through
   `ALU80_ASSERT_IMPLY(a_acc_pass, clock, reset, rsp_strobe && !rsp_data.value_written,
      rsp_data.value_out == $past(req_data.acc_in, 2))

   // zero flag agrees with the written byte
   `ALU80_ASSERT_IMPLY(a_zero_flag, clock, reset,
      rsp_strobe && rsp_data.value_written && rsp_data.flags_changed[3],
      rsp_data.zero_flag == (rsp_data.value_out == 8'd0))

endmodule

bind cpu8080_alu_with_flags alu80_checker u_alu80_checker (.*);
